// File: sv/itra_pkg.sv
`default_nettype none
package itra_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int IN_TDATA_W = ((DATA_WIDTH + RADIX_W + 7) / 8) * 8;
  localparam int IDX_W      = $clog2(DATA_WIDTH);
  localparam int CNT_W      = $clog2(DATA_WIDTH + 1);
  localparam int DCNT_W     = $clog2(DATA_WIDTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_NINE = 6'd9;

  localparam logic [CHAR_W-1:0] CHR_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CHR_LETTER = 8'h61;
  localparam logic [CHAR_W-1:0] CHR_LAST_LETTER = 8'h7a;
  localparam logic [CHAR_W-1:0] CHR_MINUS  = 8'h2d;

  typedef struct packed {
    logic                  done;
    logic [DATA_WIDTH-1:0] quot;
    logic [RADIX_W-1:0]    rem;
  } div_res_t;

  function automatic logic [RADIX_W-1:0] radix_sat(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r inside {[6'd0:6'd1]}) begin
      res = RADIX_MIN;
    end else if (r inside {[6'd37:6'd63]}) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_NINE) begin
      c = CHR_LETTER + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/itra_divider.sv
`default_nettype none
module itra_divider (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [itra_pkg::DATA_WIDTH-1:0] dividend,
  input  wire logic [itra_pkg::RADIX_W-1:0]    divisor,
  output itra_pkg::div_res_t                  res
);
  import itra_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DCNT_W-1:0]     cnt_r;
  logic [DATA_WIDTH-1:0] q_r;
  logic [RADIX_W-1:0]    rem_r;
  logic [RADIX_W-1:0]    dvs_r;

  logic [RADIX_W:0]      shifted;
  logic [RADIX_W:0]      diff;
  logic                  ge;
  logic [RADIX_W-1:0]    rem_nxt;
  logic [DATA_WIDTH-1:0] q_nxt;

  always_comb begin
    shifted = {rem_r, q_r[DATA_WIDTH-1]};
    ge      = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
    rem_nxt = ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
    q_nxt   = {q_r[DATA_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DATA_WIDTH);
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = q_r;
  assign res.rem  = rem_r;

endmodule
`default_nettype wire

// File: sv/integer_to_radix_ascii_unit.sv
`default_nettype none
// Each digit comes from one run of the itra_divider;
// one restoring shift-subtract divider step per cycle.
// A new item is accepted only after the last character of the previous one is issued;
// not ready while converting.
// Reset: synchronous, active low; clears sequencer, divider control and output valid.
module integer_to_radix_ascii_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // value [DATA_WIDTH-1:0], radix [DATA_WIDTH+5:DATA_WIDTH], zero fill above
  input  wire logic [itra_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // ch [7:0]
  output logic [itra_pkg::CHAR_W-1:0]          out_tdata,
  output logic                                 out_tlast
);
  import itra_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t                state_r;
  logic                  neg_r;
  logic [RADIX_W-1:0]    radix_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [IDX_W-1:0]      idx_r;
  logic [RADIX_W-1:0]    store_r [DATA_WIDTH];
  logic                  out_tvalid_r;
  logic [CHAR_W-1:0]     out_tdata_r;
  logic                  out_tlast_r;

  logic [DATA_WIDTH-1:0] in_value;
  logic [RADIX_W-1:0]    in_radix;
  logic [RADIX_W-1:0]    radix_in_sat;
  logic                  in_neg;
  logic [DATA_WIDTH-1:0] in_mag;
  logic                  accept;
  logic                  out_free;
  logic                  div_start;
  logic [DATA_WIDTH-1:0] div_operand;
  logic [RADIX_W-1:0]    div_divisor;
  div_res_t              div_res;

  always_comb begin
    in_value     = in_tdata[DATA_WIDTH-1:0];
    in_radix     = in_tdata[DATA_WIDTH+RADIX_W-1:DATA_WIDTH];
    radix_in_sat = radix_sat(in_radix);
    in_neg       = in_value[DATA_WIDTH-1];
    in_mag       = in_neg ? (~in_value + 1'b1) : in_value;
    accept       = in_tvalid && in_tready;
    out_free     = !out_tvalid_r || out_tready;
    div_start    = accept ||
                   (state_r == S_DIV && div_res.done && div_res.quot != '0);
    div_operand  = accept ? in_mag : div_res.quot;
    div_divisor  = accept ? radix_in_sat : radix_r;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  itra_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_operand),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            neg_r   <= in_neg;
            radix_r <= radix_in_sat;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            if (cnt_r < CNT_W'(DATA_WIDTH)) begin
              store_r[cnt_r[IDX_W-1:0]] <= div_res.rem;
              cnt_r <= cnt_r + 1'b1;
            end
            if (div_res.quot == '0) begin
              if (cnt_r < CNT_W'(DATA_WIDTH)) begin
                idx_r <= cnt_r[IDX_W-1:0];
              end else begin
                idx_r <= IDX_W'(DATA_WIDTH - 1);
              end
              state_r <= neg_r ? S_SIGN : S_EMIT;
            end
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= CHR_MINUS;
            out_tlast_r  <= 1'b0;
            state_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= digit_char(store_r[idx_r]);
            out_tlast_r  <= (idx_r == '0);
            if (idx_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r - 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DATA_WIDTH))
    else $error("digit count exceeds store depth");

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DIV && cnt_r == '0))
    else $error("accepted item did not start conversion");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata != CHR_MINUS) |->
      ((out_tdata >= CHR_ZERO && out_tdata <= CHR_NINE) ||
       (out_tdata >= CHR_LETTER && out_tdata <= CHR_LAST_LETTER)))
    else $error("emitted character is not a digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == CHR_MINUS) |-> !out_tlast)
    else $error("sign marked as last character");

  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIGN || state_r == S_EMIT) |-> !div_res.done)
    else $error("divider finished outside conversion");
`endif

endmodule
`default_nettype wire

// File: tb/itra_text_checker.sv
module itra_text_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [itra_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [itra_pkg::CHAR_W-1:0]     out_tdata,
  input  wire logic                            out_tlast,
  output int                                   mismatches,
  output int                                   chars_pending,
  output int                                   chars_checked,
  output int                                   numbers_taken
);
  timeunit 1ns;
  timeprecision 1ps;
  import itra_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  text_char_t expected_text[$];

  int err_count   = 0;
  int pend_count  = 0;
  int check_count = 0;
  int take_count  = 0;

  assign mismatches    = err_count;
  assign chars_pending = pend_count;
  assign chars_checked = check_count;
  assign numbers_taken = take_count;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    if (d > DIGIT_NINE) begin
      return CHR_LETTER + CHAR_W'(d - DIGIT_TEN);
    end
    return CHR_ZERO + CHAR_W'(d);
  endfunction

  // queue the characters of one number, most significant first
  function automatic void format_number(input logic [DATA_WIDTH-1:0] value,
                                        input logic [RADIX_W-1:0] radix_in);
    logic [RADIX_W-1:0]    base;
    logic [DATA_WIDTH-1:0] mag;
    logic [RADIX_W-1:0]    digits[$];
    logic                  neg;
    base = radix_in;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    neg = value[DATA_WIDTH-1];
    mag = neg ? (~value + 1'b1) : value;
    do begin
      digits.push_back(RADIX_W'(mag % DATA_WIDTH'(base)));
      mag = mag / DATA_WIDTH'(base);
    end while (mag != '0);
    if (neg) begin
      expected_text.push_back('{CHR_MINUS, 1'b0});
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      expected_text.push_back('{digit_to_ascii(digits[i]), i == 0});
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        format_number(in_tdata[DATA_WIDTH-1:0], in_tdata[DATA_WIDTH+RADIX_W-1:DATA_WIDTH]);
        take_count++;
      end
      if (out_tvalid && out_tready) begin
        check_count++;
        if (expected_text.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected char 0x%02h last %0d at %0t", out_tdata, out_tlast, $realtime);
          end
        end else begin
          want = expected_text.pop_front();
          if (want.ch !== out_tdata || want.last !== out_tlast) begin
            err_count++;
            if (err_count <= 10) begin
              $display("char mismatch at %0t: expected 0x%02h last %0d, got 0x%02h last %0d",
                       $realtime, want.ch, want.last, out_tdata, out_tlast);
            end
          end
        end
      end
      pend_count = expected_text.size();
    end
  end

endmodule

// File: tb/integer_to_radix_ascii_unit_tb.sv
module integer_to_radix_ascii_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itra_pkg::*;

  localparam int RANDOM_NUMBERS = 330;
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int DRAIN_CYCLES   = 300;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [CHAR_W-1:0]     out_tdata;
  logic                  out_tlast;

  int mismatches;
  int chars_pending;
  int chars_checked;
  int numbers_taken;
  int cycle_count  = 0;
  int ready_hold   = 0;
  bit steady_flow  = 1'b0;

  always #5 clk = ~clk;

  integer_to_radix_ascii_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  itra_text_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked),
    .numbers_taken (numbers_taken)
  );

  function automatic int idle_cycles();
    int sel;
    sel = $urandom_range(0, 99);
    if (steady_flow || sel < 55) begin
      return 0;
    end else if (sel < 85) begin
      return $urandom_range(1, 3);
    end else if (sel < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady_flow || $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b0;
      ready_hold <= idle_cycles();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold the item until accepted; lower valid only when a gap follows
  task automatic send_number(input logic [DATA_WIDTH-1:0] value,
                             input logic [RADIX_W-1:0] radix);
    int gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({radix, value});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random_number();
    logic [DATA_WIDTH-1:0] value;
    logic [RADIX_W-1:0]    radix;
    int                    sel;
    int                    span;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      value = DATA_WIDTH'($urandom());
    end else if (sel < 50) begin
      value = DATA_WIDTH'($urandom_range(0, 80) - 40);
    end else if (sel < 60) begin
      value = $urandom_range(0, 1) ? DATA_WIDTH'(16'h8000 + $urandom_range(0, 3))
                                   : DATA_WIDTH'(16'h7fff - $urandom_range(0, 3));
    end else begin
      span  = $urandom_range(1, DATA_WIDTH - 1);
      value = DATA_WIDTH'($urandom() & ((1 << span) - 1));
      if ($urandom_range(0, 1)) begin
        value = ~value + 1'b1;
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 75) begin
      radix = RADIX_W'($urandom_range(2, 36));
    end else if (sel < 88) begin
      case ($urandom_range(0, 3))
        0:       radix = RADIX_MIN;
        1:       radix = 6'd10;
        2:       radix = 6'd16;
        default: radix = RADIX_MAX;
      endcase
    end else begin
      radix = RADIX_W'($urandom_range(0, 63));
    end
    send_number(value, radix);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_number(16'd0, 6'd10);
    send_number(16'd0, RADIX_MIN);
    send_number(16'h7fff, RADIX_MIN);
    send_number(16'h8000, RADIX_MIN);
    send_number(16'h8000, 6'd10);
    send_number(16'h8000, 6'd16);
    send_number(16'h8000, RADIX_MAX);
    send_number(16'h8001, 6'd8);
    send_number(16'hffff, RADIX_MAX);
    send_number(16'hffff, RADIX_MIN);
    send_number(16'd35, RADIX_MAX);
    send_number(16'd9, 6'd10);
    send_number(16'd10, 6'd16);
    send_number(16'd12345, 6'd10);
    send_number(16'h5a5a, 6'd0);
    send_number(16'ha5a5, 6'd1);
    send_number(16'd1295, 6'd37);
    send_number(16'h7fff, 6'd63);
    send_number(16'h7fff, 6'd42);
    send_number(16'd1, 6'd3);
    send_number(16'hfffe, 6'd21);

    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      steady_flow = (n >= 150 && n < 200);
      send_random_number();
    end
    in_tvalid <= 1'b0;
    steady_flow = 1'b0;

    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d numbers in bases 2 to 36, including saturated bases,", numbers_taken);
    $display("zero and both extremes; %0d characters checked", chars_checked);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
